FILE: hdl/kl_pkg.sv
// Shared types, constants and character helpers for the keyword lexer.
package kl_pkg;

   localparam int WORD_MAX_DEF = 32;
   localparam int WORD_MAX_HI  = 63;
   localparam int LEN_W        = $clog2(WORD_MAX_HI + 1);
   localparam int CLS_W        = 4;
   localparam int NUM_KW       = 10;

   localparam logic [CLS_W-1:0] CLS_NUMBER = 4'd10;
   localparam logic [CLS_W-1:0] CLS_STRING = 4'd11;
   localparam logic [CLS_W-1:0] CLS_IDENT  = 4'd12;
   localparam logic [CLS_W-1:0] CLS_SYMBOL = 4'd13;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // keyword text, right-justified, first character in the highest used byte
   localparam logic [47:0] KW_TEXT [NUM_KW] = '{
      48'("func"), 48'("type"), 48'("begin"), 48'("end"), 48'("if"),
      48'("else"), 48'("while"), 48'("for"), 48'("ptr"), 48'("struct")
   };
   localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
      6'd4, 6'd4, 6'd5, 6'd3, 6'd2, 6'd4, 6'd5, 6'd3, 6'd3, 6'd6
   };

   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
      logic [CLS_W-1:0] cls;
      logic             ovf;
   } desc_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic [CLS_W-1:0] cls;
      logic             last;
      logic             ovf;
   } tok_type;

   function automatic logic is_sep(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'h20 || c == 8'h2C ||
             c == 8'h3A || c == 8'h3B;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h37;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic is_wordch(input logic [7:0] c);
      return is_dec(c) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
   endfunction

   // character p of keyword k; only meaningful for p below the keyword length
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [LEN_W-1:0] p);
      logic [47:0]      txt;
      logic [LEN_W-1:0] sh;
      txt = KW_TEXT[k];
      sh  = LEN_W'(KW_LEN[k] - p - 1'b1);
      return txt[{sh[2:0], 3'b000} +: 8];
   endfunction

endpackage

FILE: hdl/keyword_lexer.sv
// Top level of the keyword lexer: front end, descriptor queue, word RAM and back end.
//
//   channel   direction  handshake         payload
//   req       in         req_push/req_full  req_ch, req_is_end
//   rsp       out        rsp_pop/rsp_empty  rsp_tok_char, rsp_tok_class, rsp_tok_last,
//                                           rsp_tok_overflow
//
// The front end takes one item per cycle while req_full is low and writes each word
// into one of two RAM banks. A finished word passes the queue, word register, RAM read
// and output queue as one result per buffered character, one per cycle while it has room.
// req_full rises while the bank the next word needs is still being read out by the back end.
// Reset is synchronous; the word RAM needs no clearing, so items are taken right after it.
module keyword_lexer import kl_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_ch,
   input  logic             req_is_end,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_tok_char,
   output logic [CLS_W-1:0] rsp_tok_class,
   output logic             rsp_tok_last,
   output logic             rsp_tok_overflow
);

   localparam int IW = $clog2(WORD_MAX);

   logic          wr_en, rd_en;
   logic [IW:0]   wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic          desc_push, q_valid, q_pop;
   desc_type      desc, q_head;
   rel_type       rel;
   tok_type       tok;

   kl_front #(.WORD_MAX(WORD_MAX), .IW(IW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (req_push),
      .in_full   (req_full),
      .in_ch     (req_ch),
      .in_is_end (req_is_end),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .desc_push (desc_push),
      .desc      (desc),
      .rel       (rel)
   );

   kl_dq u_dq (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (desc),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   kl_ram #(.WIDTH(8), .DEPTH(2 ** (IW + 1))) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kl_back #(.WORD_MAX(WORD_MAX), .IW(IW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rel       (rel),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_tok   (tok)
   );

   assign rsp_tok_char     = tok.ch;
   assign rsp_tok_class    = tok.cls;
   assign rsp_tok_last     = tok.last;
   assign rsp_tok_overflow = tok.ovf;

endmodule

FILE: hdl/kl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/kl_front.sv
// Front end: splits the character stream into words, buffers them and classifies them.
module kl_front import kl_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEF,
   parameter int IW       = $clog2(WORD_MAX)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_push,
   output logic          in_full,
   input  logic [7:0]    in_ch,
   input  logic          in_is_end,
   output logic          wr_en,
   output logic [IW:0]   wr_addr,
   output logic [7:0]    wr_data,
   output logic          desc_push,
   output desc_type      desc,
   input  rel_type       rel
);

   localparam int LW = $clog2(WORD_MAX + 1);

   localparam logic [2:0] N_START = 3'd0;
   localparam logic [2:0] N_SIGN  = 3'd1;
   localparam logic [2:0] N_ZERO  = 3'd2;
   localparam logic [2:0] N_OCT   = 3'd3;
   localparam logic [2:0] N_ZX    = 3'd4;
   localparam logic [2:0] N_HEX   = 3'd5;
   localparam logic [2:0] N_DEC   = 3'd6;
   localparam logic [2:0] N_FAIL  = 3'd7;

   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;
   logic              open_ff, open_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              smode_ff, smode_in;
   logic              drop_ff, drop_in;
   logic              alnum_ff, alnum_in;
   logic              firstq_ff, firstq_in;
   logic [NUM_KW-1:0] kw_ff, kw_in;
   logic [2:0]        num_ff, num_in;

   logic              accept, sep, wch, same_kind;
   logic              flush, cont, start, app, room, wbank;
   logic [LW-1:0]     base_len;
   logic              base_smode, base_drop;
   logic [NUM_KW-1:0] base_kw, step_kw;
   logic [2:0]        base_num, step_num;
   logic [LEN_W-1:0]  pos;
   logic [CLS_W-1:0]  cls;

   assign in_full = busy_ff[bank_ff] | (open_ff & busy_ff[~bank_ff]);
   assign accept  = in_push & ~in_full;
   assign sep       = is_sep(in_ch);
   assign wch       = is_wordch(in_ch);
   assign same_kind = ~sep & (wch == alnum_ff);

   assign flush = accept & open_ff & (in_is_end | ~(smode_ff | same_kind));
   assign cont  = accept & ~in_is_end & open_ff & (smode_ff | same_kind);
   assign start = accept & ~in_is_end & ~sep & ~cont;
   assign app   = cont | start;
   assign wbank = flush ? ~bank_ff : bank_ff;

   assign base_len   = start ? '0 : len_ff;
   assign base_smode = start ? 1'b0 : smode_ff;
   assign base_drop  = start ? 1'b0 : drop_ff;
   assign base_kw    = start ? '1 : kw_ff;
   assign base_num   = start ? N_START : num_ff;
   assign room       = base_len < LW'(WORD_MAX);
   assign pos        = LEN_W'(base_len);

   // keyword prefix match and number recognizer, advanced once per buffered character
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         step_kw[k] = base_kw[k] & (pos < KW_LEN[k]) & (in_ch == kw_char(4'(k), pos));
      end
      step_num = N_FAIL;
      case (base_num)
         N_START: begin
            if (in_ch == CH_PLUS || in_ch == CH_MINUS) step_num = N_SIGN;
            else if (in_ch == CH_ZERO) step_num = N_ZERO;
            else if (is_dec(in_ch)) step_num = N_DEC;
         end
         N_SIGN: begin
            if (in_ch == CH_ZERO) step_num = N_ZERO;
            else if (is_dec(in_ch)) step_num = N_DEC;
         end
         N_ZERO: begin
            if (is_oct(in_ch)) step_num = N_OCT;
            else if (in_ch == 8'h78 || in_ch == 8'h58) step_num = N_ZX;
         end
         N_OCT: begin
            if (is_oct(in_ch)) step_num = N_OCT;
         end
         N_ZX, N_HEX: begin
            if (is_hex(in_ch)) step_num = N_HEX;
         end
         N_DEC: begin
            if (is_dec(in_ch)) step_num = N_DEC;
         end
         default: step_num = N_FAIL;
      endcase
   end

   // class of the word held in the registers
   always_comb begin
      if (num_ff == N_ZERO || num_ff == N_OCT || num_ff == N_HEX || num_ff == N_DEC)
         cls = CLS_NUMBER;
      else if (firstq_ff)
         cls = CLS_STRING;
      else if (alnum_ff)
         cls = CLS_IDENT;
      else
         cls = CLS_SYMBOL;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (kw_ff[k] && LEN_W'(len_ff) == KW_LEN[k]) cls = CLS_W'(k);
      end
   end

   assign desc_push = flush;
   assign desc.bank = bank_ff;
   assign desc.len  = LEN_W'(len_ff);
   assign desc.cls  = cls;
   assign desc.ovf  = drop_ff;

   assign wr_en   = app & room;
   assign wr_addr = {wbank, base_len[IW-1:0]};
   assign wr_data = in_ch;

   always_comb begin
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      open_in   = open_ff;
      len_in    = len_ff;
      smode_in  = smode_ff;
      drop_in   = drop_ff;
      alnum_in  = alnum_ff;
      firstq_in = firstq_ff;
      kw_in     = kw_ff;
      num_in    = num_ff;
      if (rel.valid) busy_in[rel.bank] = 1'b0;
      if (flush) begin
         busy_in[bank_ff] = 1'b1;
         bank_in          = ~bank_ff;
      end
      if (app) begin
         open_in  = 1'b1;
         len_in   = room ? LW'(base_len + 1'b1) : base_len;
         smode_in = base_smode ^ (in_ch == CH_QUOTE);
         drop_in  = base_drop | ~room;
         kw_in    = room ? step_kw : base_kw;
         num_in   = room ? step_num : base_num;
         if (start) begin
            alnum_in  = wch;
            firstq_in = (in_ch == CH_QUOTE);
         end
      end else if (flush || (accept && in_is_end)) begin
         open_in  = 1'b0;
         len_in   = '0;
         smode_in = 1'b0;
         drop_in  = 1'b0;
         alnum_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
         open_ff  <= 1'b0;
         len_ff   <= '0;
         smode_ff <= 1'b0;
         drop_ff  <= 1'b0;
         alnum_ff <= 1'b0;
      end else begin
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         open_ff  <= open_in;
         len_ff   <= len_in;
         smode_ff <= smode_in;
         drop_ff  <= drop_in;
         alnum_ff <= alnum_in;
      end
   end

   always_ff @(posedge clock) begin
      firstq_ff <= firstq_in;
      kw_ff     <= kw_in;
      num_ff    <= num_in;
   end

endmodule

FILE: hdl/kl_dq.sv
// Two-entry queue of finished-word descriptors between front and back end.
module kl_dq import kl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     valid,
   output desc_type head
);

   desc_type   q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign valid   = cnt_ff != 2'd0;
   assign head    = q_ff[rd_ptr_ff];
   assign do_push = push & (cnt_ff != 2'd2);
   assign do_pop  = pop & valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

FILE: hdl/kl_back.sv
// Back end: reads each buffered word out of the RAM and queues its tagged characters.
module kl_back import kl_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEF,
   parameter int IW       = $clog2(WORD_MAX)
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  desc_type   q_head,
   output logic       q_pop,
   output logic       rd_en,
   output logic [IW:0] rd_addr,
   input  logic [7:0] rd_data,
   output rel_type    rel,
   output logic       out_empty,
   input  logic       out_pop,
   output tok_type    out_tok
);

   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);

   desc_type         cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             pend_ff;
   logic [CLS_W-1:0] pend_cls_ff;
   logic             pend_last_ff, pend_ovf_ff;

   tok_type          oq_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] oq_wr_ff, oq_rd_ff;
   logic [OQ_AW:0]   oq_cnt_ff;

   logic issue, is_last, load, oq_pop;

   // keep room for the read in flight plus the new one
   assign issue   = cur_valid_ff & ((oq_cnt_ff + {{OQ_AW{1'b0}}, pend_ff}) < (OQ_AW + 1)'(OQ_DEPTH));
   assign is_last = LEN_W'(LEN_W'(idx_ff) + 1'b1) == cur_ff.len;
   assign load    = q_valid & (~cur_valid_ff | (issue & is_last));
   assign q_pop   = load;

   assign rd_en   = issue;
   assign rd_addr = {cur_ff.bank, idx_ff};

   assign rel.valid = issue & is_last;
   assign rel.bank  = cur_ff.bank;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (issue) begin
         idx_in = IW'(idx_ff + 1'b1);
         if (is_last) cur_valid_in = 1'b0;
      end
      if (load) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   assign oq_pop    = out_pop & ~out_empty;
   assign out_empty = oq_cnt_ff == '0;
   assign out_tok   = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         oq_wr_ff     <= '0;
         oq_rd_ff     <= '0;
         oq_cnt_ff    <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pend_ff      <= issue;
         if (pend_ff) oq_wr_ff <= OQ_AW'(oq_wr_ff + 1'b1);
         if (oq_pop) oq_rd_ff <= OQ_AW'(oq_rd_ff + 1'b1);
         oq_cnt_ff <= oq_cnt_ff + {{OQ_AW{1'b0}}, pend_ff} - {{OQ_AW{1'b0}}, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      pend_cls_ff  <= cur_ff.cls;
      pend_last_ff <= is_last;
      pend_ovf_ff  <= cur_ff.ovf;
      if (pend_ff) begin
         oq_ff[oq_wr_ff] <= '{ch: rd_data, cls: pend_cls_ff, last: pend_last_ff,
                              ovf: pend_ovf_ff};
      end
   end

endmodule

FILE: tb/lexer_token_check.sv
// Token checker for the keyword lexer: watches both channels, predicts each token and compares.
module lexer_token_check import kl_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  logic [7:0]       req_ch,
   input  logic             req_is_end,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  logic [7:0]       rsp_tok_char,
   input  logic [CLS_W-1:0] rsp_tok_class,
   input  logic             rsp_tok_last,
   input  logic             rsp_tok_overflow,
   output int               mismatches,
   output int               tokens_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [CLS_W-1:0] {
      KW_FUNC, KW_TYPE, KW_BEGIN, KW_END, KW_IF, KW_ELSE, KW_WHILE, KW_FOR, KW_PTR, KW_STRUCT
   } keyword_type;

   logic [7:0]       word_buf [WORD_MAX];
   logic [LEN_W-1:0] word_len;
   logic             quote_mode;
   logic             word_is_alnum;
   logic             word_active;
   logic             chars_dropped;
   tok_type          expected_toks [$];

   task automatic report(input string msg);
      $display("ERROR %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic string spelling(input keyword_type k);
      case (k)
         KW_FUNC:   return "func";
         KW_TYPE:   return "type";
         KW_BEGIN:  return "begin";
         KW_END:    return "end";
         KW_IF:     return "if";
         KW_ELSE:   return "else";
         KW_WHILE:  return "while";
         KW_FOR:    return "for";
         KW_PTR:    return "ptr";
         default:   return "struct";
      endcase
   endfunction

   function automatic logic sep_char(input logic [7:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == " " || c == "," || c == ":" || c == ";";
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             c == "_";
   endfunction

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
   endfunction

   // optional sign, then 0x-hex, 0-octal or decimal digits running to the end of the word
   function automatic logic number_word();
      int i;
      int start;
      int base;
      i = 0;
      if (word_len == 0) return 1'b0;
      if (word_buf[0] == CH_PLUS || word_buf[0] == CH_MINUS) i = 1;
      if (i + 2 < word_len && word_buf[i] == CH_ZERO &&
          (word_buf[i+1] == "x" || word_buf[i+1] == "X") && digit_value(word_buf[i+2]) < 16) begin
         base = 16;
         i += 2;
      end else if (i < word_len && word_buf[i] == CH_ZERO) begin
         base = 8;
      end else begin
         base = 10;
      end
      start = i;
      while (i < word_len && digit_value(word_buf[i]) < base) i++;
      return i > start && i == word_len;
   endfunction

   function automatic logic [CLS_W-1:0] word_class();
      int    k;
      int    p;
      string sp;
      logic  hit;
      for (k = 0; k < NUM_KW; k++) begin
         sp = spelling(keyword_type'(k));
         if (word_len == sp.len()) begin
            hit = 1'b1;
            for (p = 0; p < sp.len(); p++)
               if (word_buf[p] != sp[p]) hit = 1'b0;
            if (hit) return CLS_W'(k);
         end
      end
      if (number_word()) return CLS_NUMBER;
      if (word_len > 0 && word_buf[0] == CH_QUOTE) return CLS_STRING;
      if (word_is_alnum) return CLS_IDENT;
      return CLS_SYMBOL;
   endfunction

   function automatic void clear_word();
      word_len      = '0;
      quote_mode    = 1'b0;
      word_is_alnum = 1'b0;
      word_active   = 1'b0;
      chars_dropped = 1'b0;
   endfunction

   function automatic void emit_word();
      logic [CLS_W-1:0] cls;
      tok_type          t;
      int               k;
      cls = word_class();
      for (k = 0; k < word_len; k++) begin
         t.ch   = word_buf[k];
         t.cls  = cls;
         t.last = (k + 1 == word_len);
         t.ovf  = chars_dropped;
         expected_toks.push_back(t);
      end
      clear_word();
   endfunction

   // quotes still toggle string mode when the buffer is full and they are dropped
   function automatic void add_char(input logic [7:0] c);
      if (c == CH_QUOTE) quote_mode = !quote_mode;
      if (word_len < WORD_MAX) begin
         word_buf[word_len] = c;
         word_len++;
      end else begin
         chars_dropped = 1'b1;
      end
   endfunction

   function automatic void lex_step(input logic [7:0] c, input logic is_end);
      if (is_end) begin
         if (word_active) emit_word();
         clear_word();
         return;
      end
      if (word_active) begin
         if (quote_mode || (!sep_char(c) && word_char(c) == word_is_alnum)) begin
            add_char(c);
            return;
         end
         emit_word();
      end
      if (sep_char(c)) return;
      word_is_alnum = word_char(c);
      word_active   = 1'b1;
      add_char(c);
   endfunction

   task automatic check_token();
      tok_type want;
      if (expected_toks.size() == 0) begin
         report($sformatf("token ch=%02h cls=%0d last=%0b ovf=%0b with nothing expected",
                          rsp_tok_char, rsp_tok_class, rsp_tok_last, rsp_tok_overflow));
         return;
      end
      want = expected_toks.pop_front();
      if (rsp_tok_char !== want.ch || rsp_tok_class !== want.cls ||
          rsp_tok_last !== want.last || rsp_tok_overflow !== want.ovf)
         report($sformatf("token ch=%02h cls=%0d last=%0b ovf=%0b, expected ch=%02h cls=%0d last=%0b ovf=%0b",
                          rsp_tok_char, rsp_tok_class, rsp_tok_last, rsp_tok_overflow,
                          want.ch, want.cls, want.last, want.ovf));
   endtask

   // a token popped at this edge always predates the item taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_word();
         expected_toks.delete();
         mismatches = 0;
      end else begin
         if (rsp_pop && !rsp_empty) check_token();
         if (req_push && !req_full) lex_step(req_ch, req_is_end);
      end
      tokens_due = expected_toks.size();
   end

endmodule

FILE: tb/tb_keyword_lexer.sv
// Testbench top for the keyword lexer: clock, reset, character stimulus, token drain, verdict.
module tb_keyword_lexer import kl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL = 280;
   localparam int TAIL      = 20;
   localparam int TX        = 0;
   localparam int RX        = 1;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   logic [7:0]       req_ch;
   logic             req_is_end;
   logic             rsp_empty;
   logic             rsp_pop;
   logic [7:0]       rsp_tok_char;
   logic [CLS_W-1:0] rsp_tok_class;
   logic             rsp_tok_last;
   logic             rsp_tok_overflow;
   int               mismatches;
   int               tokens_due;
   int               items_sent;
   int               idle_calm [2];

   keyword_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_ch           (req_ch),
      .req_is_end       (req_is_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_tok_char     (rsp_tok_char),
      .rsp_tok_class    (rsp_tok_class),
      .rsp_tok_last     (rsp_tok_last),
      .rsp_tok_overflow (rsp_tok_overflow)
   );

   lexer_token_check token_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_ch           (req_ch),
      .req_is_end       (req_is_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_tok_char     (rsp_tok_char),
      .rsp_tok_class    (rsp_tok_class),
      .rsp_tok_last     (rsp_tok_last),
      .rsp_tok_overflow (rsp_tok_overflow),
      .mismatches       (mismatches),
      .tokens_due       (tokens_due)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   // wait before the next item; now and then a run of items with no wait at all
   function automatic int draw_gap(input int side);
      if (idle_calm[side] > 0) begin
         idle_calm[side]--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         idle_calm[side] = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] alnum_byte();
      return pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_");
   endfunction

   // neither separator nor word character, quote left out
   function automatic logic [7:0] symbol_byte();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(14, 31));
         1, 2, 3: return 8'($urandom_range(128, 255));
         default: return pick_from("!#$%&'()*+-./<=>?@[\\]^`{|}~");
      endcase
   endfunction

   function automatic logic [7:0] sep_byte();
      case ($urandom_range(0, 8))
         0, 1, 2, 3, 4: return 8'($urandom_range(9, 13));
         5:             return " ";
         6:             return ",";
         7:             return ":";
         default:       return ";";
      endcase
   endfunction

   function automatic string keyword_word(input int k);
      case (k)
         0:       return "func";
         1:       return "type";
         2:       return "begin";
         3:       return "end";
         4:       return "if";
         5:       return "else";
         6:       return "while";
         7:       return "for";
         8:       return "ptr";
         default: return "struct";
      endcase
   endfunction

   task automatic send_item(input logic [7:0] c, input logic is_end);
      int gap;
      gap = draw_gap(TX);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push   <= 1'b1;
      req_ch     <= c;
      req_is_end <= is_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_word();
      int    kind;
      int    n;
      int    i;
      string digits;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         send_text(keyword_word($urandom_range(0, 9)));
         // a trailing character turns the keyword into an identifier
         if ($urandom_range(0, 3) == 0) send_item(alnum_byte(), 1'b0);
      end else if (kind < 30) begin
         case ($urandom_range(0, 2))
            0: begin
               send_item("0", 1'b0);
               send_item($urandom_range(0, 1) ? "x" : "X", 1'b0);
               digits = "0123456789abcdefABCDEF";
               n = $urandom_range(0, 6);
            end
            1: begin
               send_item("0", 1'b0);
               digits = "01234567";
               n = $urandom_range(0, 5);
            end
            default: begin
               digits = "0123456789";
               n = $urandom_range(1, 6);
            end
         endcase
         for (i = 0; i < n; i++) send_item(pick_from(digits), 1'b0);
         if ($urandom_range(0, 5) == 0) send_item(pick_from("89gG_z"), 1'b0);
      end else if (kind < 45) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) send_item(alnum_byte(), 1'b0);
      end else if (kind < 58) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_item(symbol_byte(), 1'b0);
      end else if (kind < 72) begin
         send_item(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 10);
         for (i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
         if ($urandom_range(0, 9) < 7) send_item(CH_QUOTE, 1'b0);
      end else if (kind < 80) begin
         // around the buffer size, so words fall just short of it, fill it exactly or overflow it
         n = $urandom_range(WORD_MAX_DEF - 2, WORD_MAX_DEF + 8);
         case ($urandom_range(0, 2))
            0:       for (i = 0; i < n; i++) send_item(pick_from("0123456789"), 1'b0);
            1:       for (i = 0; i < n; i++) send_item(alnum_byte(), 1'b0);
            default: begin
               send_item(CH_QUOTE, 1'b0);
               for (i = 1; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
      end else if (kind < 90) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 9) < 7) send_item(sep_byte(), 1'b0);
   endtask

   initial begin : drain
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(RX);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   initial begin
      reset      = 1'b1;
      req_push   = 1'b0;
      req_ch     = '0;
      req_is_end = 1'b0;
      rsp_pop    = 1'b0;
      items_sent = 0;
      idle_calm  = '{0, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // end mark with no open word, keyword, hex, bad octal, string with a blank,
      // high and zero bytes as a symbol, then end mark inside string mode
      send_item(8'h41, 1'b1);
      send_text("if,0x1F");
      send_text(" 08 \"a b\"x");
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h00, 1'b0);
      send_text("\"q");
      send_item(8'h00, 1'b1);

      while (items_sent < ITEM_GOAL) send_word();
      send_item(8'($urandom_range(0, 255)), 1'b1);
      req_push <= 1'b0;

      @(posedge clock);
      while (tokens_due != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
